// ===== design/pclj_pkg.sv =====
`default_nettype none
package pclj_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
        logic [63:0]        charge_pair;
        logic [63:0]        epsilon_pair;
        logic [63:0]        sigma_pair;
        logic               last_pair;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] total_elec;
        logic signed [63:0] total_vdw;
        logic               saturated;
        logic               zero_distance;
    } t_out_word;

    typedef enum logic [4:0] {
        OP_LOAD, OP_DIFF, OP_MOD, OP_FIX, OP_SQ, OP_CUT, OP_CTN, OP_SQRT,
        OP_QM, OP_PE, OP_S, OP_S2, OP_S3, OP_S6, OP_S12, OP_EP, OP_PV,
        OP_T, OP_T2, OP_SW, OP_PES, OP_PVS, OP_ACC, OP_FLAGS, OP_TE, OP_EMIT
    } t_op;

    typedef enum logic [1:0] {U_NONE, U_MUL, U_DIV, U_SQRT} t_unit;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT} t_state;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
        logic       start;
        logic       save;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic box_zero;
        logic r2_zero;
        logic beyond;
        logic in_switch;
        logic last;
        logic out_free;
    } t_stat;

    function automatic t_unit unit_of(input t_op op);
        t_unit u;
        unique case (op) inside
            OP_SQ, OP_CUT, OP_CTN, OP_QM, OP_S2, OP_S3, OP_S6, OP_S12, OP_EP, OP_PV,
            OP_T2, OP_SW, OP_PES, OP_PVS, OP_TE: u = U_MUL;
            OP_MOD, OP_PE, OP_S, OP_T: u = U_DIV;
            OP_SQRT: u = U_SQRT;
            default: u = U_NONE;
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// ===== design/pclj_mul.sv =====
`default_nettype none
module pclj_mul
    import pclj_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    input  wire logic [1:0]  i_shift,
    output logic             o_done,
    output logic [63:0]      o_res,
    output logic             o_sat
);

    logic [63:0]  r_a, r_b;
    logic [1:0]   r_k;
    logic [127:0] r_acc;
    logic [1:0]   r_cnt;
    logic         r_busy, r_done;

    logic [31:0]  w_ap, w_bp;
    logic [63:0]  w_prod;
    logic [6:0]   w_pos;
    logic [127:0] w_shifted;
    logic [5:0]   w_ksh;
    logic [127:0] w_out;
    logic [63:0]  w_hi;

    assign w_ap      = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign w_bp      = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign w_prod    = {32'b0, w_ap} * {32'b0, w_bp};
    assign w_pos     = {r_cnt[1] & r_cnt[0], r_cnt[1] ^ r_cnt[0], 5'b0};
    assign w_shifted = {64'b0, w_prod} << w_pos;
    assign w_ksh     = {r_k, 4'b0};
    assign w_out     = r_acc >> w_ksh;
    assign w_hi      = r_acc[127:64] >> w_ksh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_k   <= i_shift;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_shifted;
        end
    end

    assign o_done = r_done;
    assign o_sat  = (w_hi != 64'd0);
    assign o_res  = o_sat ? 64'hFFFF_FFFF_FFFF_FFFF : w_out[63:0];

endmodule
`default_nettype wire

// ===== design/pclj_div.sv =====
`default_nettype none
module pclj_div
    import pclj_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_rem,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    input  wire logic [6:0]  i_steps,
    output logic             o_done,
    output logic [63:0]      o_quo,
    output logic [63:0]      o_rem
);

    logic [63:0] r_rem, r_q, r_d;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;

    logic [64:0] w_trial, w_sub;
    logic        w_ge;

    assign w_trial = {r_rem, r_q[63]};
    assign w_ge    = (w_trial >= {1'b0, r_d});
    assign w_sub   = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_q   <= i_num;
            r_d   <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[63:0] : w_trial[63:0];
            r_q   <= {r_q[62:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ===== design/pclj_sqrt.sv =====
`default_nettype none
module pclj_sqrt
    import pclj_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_val,
    output logic             o_done,
    output logic [31:0]      o_root
);

    logic [63:0] r_v, r_res, r_bit;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;

    logic [64:0] w_trial;
    logic        w_ge;

    assign w_trial = {1'b0, r_res} + {1'b0, r_bit};
    assign w_ge    = ({1'b0, r_v} >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_res <= 64'd0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (w_ge) begin
                r_v   <= r_v - w_trial[63:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule
`default_nettype wire

// ===== design/pclj_ctrl.sv =====
`default_nettype none
module pclj_ctrl
    import pclj_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output t_cmd       o_cmd,
    input  wire t_stat i_stat
);

    t_state     r_state, n_state;
    t_op        r_op, n_op;
    logic [1:0] r_axis, n_axis;

    t_op        w_nx_op;
    logic [1:0] w_nx_axis;
    logic       w_finish;
    t_unit      w_unit;

    assign w_unit = unit_of(r_op);

    always_comb begin
        w_nx_op   = OP_EMIT;
        w_nx_axis = r_axis;
        w_finish  = 1'b0;
        unique case (r_op)
            OP_DIFF: w_nx_op = i_stat.box_zero ? OP_SQ : OP_MOD;
            OP_MOD:  w_nx_op = OP_FIX;
            OP_FIX:  w_nx_op = OP_SQ;
            OP_SQ: begin
                if (r_axis == 2'd2) begin
                    w_nx_op = OP_CUT;
                end else begin
                    w_nx_op   = OP_DIFF;
                    w_nx_axis = r_axis + 2'd1;
                end
            end
            OP_CUT:  w_nx_op = OP_CTN;
            OP_CTN:  w_nx_op = (i_stat.r2_zero || i_stat.beyond) ? OP_FLAGS : OP_SQRT;
            OP_SQRT: w_nx_op = OP_QM;
            OP_QM:   w_nx_op = OP_PE;
            OP_PE:   w_nx_op = OP_S;
            OP_S:    w_nx_op = OP_S2;
            OP_S2:   w_nx_op = OP_S3;
            OP_S3:   w_nx_op = OP_S6;
            OP_S6:   w_nx_op = OP_S12;
            OP_S12:  w_nx_op = OP_EP;
            OP_EP:   w_nx_op = OP_PV;
            OP_PV:   w_nx_op = i_stat.in_switch ? OP_T : OP_ACC;
            OP_T:    w_nx_op = OP_T2;
            OP_T2:   w_nx_op = OP_SW;
            OP_SW:   w_nx_op = OP_PES;
            OP_PES:  w_nx_op = OP_PVS;
            OP_PVS:  w_nx_op = OP_ACC;
            OP_ACC:  w_nx_op = OP_FLAGS;
            OP_FLAGS: begin
                w_nx_op  = OP_TE;
                w_finish = !i_stat.last;
            end
            OP_TE:   w_nx_op = OP_EMIT;
            default: w_finish = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_axis  = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ISSUE;
                    n_op    = OP_DIFF;
                    n_axis  = 2'd0;
                end
            end
            S_ISSUE: begin
                if (w_unit != U_NONE) begin
                    n_state = S_WAIT;
                end else if (r_op != OP_EMIT || i_stat.out_free) begin
                    n_state = w_finish ? S_IDLE : S_ISSUE;
                    n_op    = w_nx_op;
                    n_axis  = w_nx_axis;
                end
            end
            S_WAIT: begin
                if (i_stat.done) begin
                    n_state = w_finish ? S_IDLE : S_ISSUE;
                    n_op    = w_nx_op;
                    n_axis  = w_nx_axis;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op    = r_op;
        o_cmd.axis  = r_axis;
        o_cmd.start = 1'b0;
        o_cmd.save  = 1'b0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.op   = OP_LOAD;
                o_cmd.save = i_in_valid;
                o_in_ready = 1'b1;
            end
            S_ISSUE: begin
                o_cmd.start = (w_unit != U_NONE);
                o_cmd.save  = (w_unit == U_NONE) && (r_op != OP_EMIT || i_stat.out_free);
            end
            S_WAIT: o_cmd.save = i_stat.done;
            default: o_cmd.save = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_LOAD;
            r_axis  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_axis  <= n_axis;
        end
    end

endmodule
`default_nettype wire

// ===== design/pclj_datapath.sv =====
`default_nettype none
module pclj_datapath
    import pclj_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    input  wire t_in_word              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_word                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTON       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEC_SCALE  = 3'd6;

    localparam logic [31:0] CUTOFF_RESET = 32'd786432;
    localparam logic [31:0] CUTON_RESET  = 32'd655360;

    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_16 = 2'd1;
    localparam logic [1:0] SH_32 = 2'd2;
    localparam logic [1:0] SH_48 = 2'd3;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    function automatic logic [64:0] signed_of(input logic [63:0] mag, input logic neg);
        logic [64:0] r;
        if (neg) begin
            if (mag > S64_MIN) r = {1'b1, S64_MIN};
            else               r = {1'b0, 64'd0 - mag};
        end else if (mag[63]) begin
            r = {1'b1, S64_MAX};
        end else begin
            r = {1'b0, mag};
        end
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        logic [64:0] r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) r = s[64] ? {1'b1, S64_MIN} : {1'b1, S64_MAX};
        else                r = {1'b0, s[63:0]};
        return r;
    endfunction

    // Configuration and accumulator state.
    logic                   r_mode;
    logic [31:0]            r_cutoff, r_cuton, r_box_x, r_box_y, r_box_z;
    logic [CFG_DATA_W-1:0]  r_scale;
    logic [63:0]            r_elec, r_vdw;
    logic                   r_satf, r_coinf, r_out_valid;

    // Per-pair working registers.
    t_in_word    r_in;
    logic [33:0] r_d;
    logic [63:0] r_r2, r_ctoff2, r_cton2, r_qmag, r_pe, r_s, r_s2, r_s3, r_s6, r_s12;
    logic [63:0] r_eprod, r_pv, r_t, r_t2, r_sw, r_te;
    logic [31:0] r_r;
    logic        r_isat, r_fsat;
    t_out_word   r_out;

    logic        w_mul_start, w_div_start, w_sqrt_start;
    logic [63:0] w_mul_a, w_mul_b;
    logic [1:0]  w_mul_k;
    logic [63:0] w_div_rem, w_div_num, w_div_den;
    logic [6:0]  w_div_steps;
    logic        w_mul_done, w_div_done, w_sqrt_done, w_mul_sat, w_mul_neg;
    logic [63:0] w_mul_res, w_div_quo, w_div_rem_out;
    logic [31:0] w_root;

    logic [31:0] w_box, w_fst, w_sec;
    logic [33:0] w_diff, w_dmag, w_m0, w_m;
    logic [31:0] w_qi_mag, w_qj_mag;
    logic        w_qneg, w_vneg, w_tv_ok, w_op_sat;
    logic [32:0] w_ssum;
    logic [63:0] w_vdiff, w_f;
    logic [64:0] w_r2_sum, w_so_mul, w_so_div, w_add_e, w_add_v;

    always_comb begin
        unique case (i_cmd.axis)
            2'd0: begin
                w_box = r_box_x;
                w_fst = r_in.first_x;
                w_sec = r_in.second_x;
            end
            2'd1: begin
                w_box = r_box_y;
                w_fst = r_in.first_y;
                w_sec = r_in.second_y;
            end
            default: begin
                w_box = r_box_z;
                w_fst = r_in.first_z;
                w_sec = r_in.second_z;
            end
        endcase
    end

    assign w_diff = {{2{w_sec[31]}}, w_sec} - {{2{w_fst[31]}}, w_fst};
    assign w_dmag = r_d[33] ? 34'd0 - r_d : r_d;
    assign w_m0   = (r_d[33] && w_div_rem_out[31:0] != 32'd0)
                  ? {2'b0, w_box} - {2'b0, w_div_rem_out[31:0]}
                  : {2'b0, w_div_rem_out[31:0]};
    assign w_m    = ({w_m0, 1'b0} > {3'b0, w_box}) ? w_m0 - {2'b0, w_box} : w_m0;

    assign w_qi_mag = r_in.charge_pair[31] ? 32'd0 - r_in.charge_pair[31:0]
                                           : r_in.charge_pair[31:0];
    assign w_qj_mag = r_in.charge_pair[63] ? 32'd0 - r_in.charge_pair[63:32]
                                           : r_in.charge_pair[63:32];
    assign w_qneg   = r_in.charge_pair[31] ^ r_in.charge_pair[63];
    assign w_ssum   = {1'b0, r_in.sigma_pair[31:0]} + {1'b0, r_in.sigma_pair[63:32]};
    assign w_vneg   = (r_s12 < r_s6);
    assign w_vdiff  = w_vneg ? r_s6 - r_s12 : r_s12 - r_s6;
    assign w_f      = {32'd3, 32'd0} - {r_t[62:0], 1'b0};
    assign w_r2_sum = {1'b0, r_r2} + {1'b0, w_mul_res};
    assign w_tv_ok  = (r_vdw[63:61] == 3'b000) || (r_vdw[63:61] == 3'b111);

    always_comb begin
        w_mul_a     = 64'd0;
        w_mul_b     = 64'd0;
        w_mul_k     = SH_0;
        w_mul_neg   = 1'b0;
        w_div_rem   = 64'd0;
        w_div_num   = 64'd0;
        w_div_den   = r_s;
        w_div_steps = 7'd64;
        unique case (i_cmd.op) inside
            OP_SQ: begin
                w_mul_a = {30'b0, w_dmag};
                w_mul_b = {30'b0, w_dmag};
            end
            OP_CUT: begin
                w_mul_a = {32'b0, r_cutoff};
                w_mul_b = {32'b0, r_cutoff};
            end
            OP_CTN: begin
                w_mul_a = {32'b0, r_cuton};
                w_mul_b = {32'b0, r_cuton};
            end
            OP_QM: begin
                w_mul_a = {32'b0, w_qi_mag};
                w_mul_b = {32'b0, w_qj_mag};
            end
            OP_S2: begin
                w_mul_a = r_s;
                w_mul_b = r_s;
                w_mul_k = SH_32;
            end
            OP_S3: begin
                w_mul_a = r_s2;
                w_mul_b = r_s;
                w_mul_k = SH_32;
            end
            OP_S6: begin
                w_mul_a = r_s3;
                w_mul_b = r_s3;
                w_mul_k = SH_32;
            end
            OP_S12: begin
                w_mul_a = r_s6;
                w_mul_b = r_s6;
                w_mul_k = SH_32;
            end
            OP_EP: begin
                w_mul_a = {32'b0, r_in.epsilon_pair[31:0]};
                w_mul_b = {32'b0, r_in.epsilon_pair[63:32]};
            end
            OP_PV: begin
                w_mul_a   = r_eprod;
                w_mul_b   = w_vdiff;
                w_mul_k   = SH_48;
                w_mul_neg = w_vneg;
            end
            OP_T2: begin
                w_mul_a = r_t;
                w_mul_b = r_t;
                w_mul_k = SH_32;
            end
            OP_SW: begin
                w_mul_a = r_t2;
                w_mul_b = w_f;
                w_mul_k = SH_32;
            end
            OP_PES: begin
                w_mul_a   = mag64(r_pe);
                w_mul_b   = r_sw;
                w_mul_k   = SH_32;
                w_mul_neg = r_pe[63];
            end
            OP_PVS: begin
                w_mul_a   = mag64(r_pv);
                w_mul_b   = r_sw;
                w_mul_k   = SH_32;
                w_mul_neg = r_pv[63];
            end
            OP_TE: begin
                w_mul_a   = mag64(r_elec);
                w_mul_b   = {{(64 - CFG_DATA_W){1'b0}}, r_scale};
                w_mul_k   = SH_16;
                w_mul_neg = r_elec[63];
            end
            OP_MOD: begin
                w_div_num   = {w_dmag[32:0], 31'b0};
                w_div_den   = {32'b0, w_box};
                w_div_steps = 7'd33;
            end
            OP_PE: begin
                w_div_num = r_qmag;
                w_div_den = {32'b0, r_r};
            end
            OP_S: begin
                w_div_num = {7'b0, w_ssum, 24'b0};
                w_div_den = {32'b0, r_r};
            end
            OP_T: begin
                w_div_rem   = r_ctoff2 - r_r2;
                w_div_den   = r_ctoff2 - r_cton2;
                w_div_steps = 7'd32;
            end
            default: w_div_steps = 7'd64;
        endcase
    end

    assign w_mul_start  = i_cmd.start && (unit_of(i_cmd.op) == U_MUL);
    assign w_div_start  = i_cmd.start && (unit_of(i_cmd.op) == U_DIV);
    assign w_sqrt_start = i_cmd.start && (unit_of(i_cmd.op) == U_SQRT);

    pclj_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .i_shift (w_mul_k),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res),
        .o_sat   (w_mul_sat)
    );

    pclj_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_rem   (w_div_rem),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .i_steps (w_div_steps),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem_out)
    );

    pclj_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_val   (r_r2),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    assign w_so_mul = signed_of(w_mul_res, w_mul_neg);
    assign w_so_div = signed_of(w_div_quo, w_qneg);
    assign w_add_e  = sat_add(r_elec, r_pe);
    assign w_add_v  = sat_add(r_vdw, r_pv);

    always_comb begin
        unique case (i_cmd.op) inside
            OP_SQ:                                  w_op_sat = w_r2_sum[64];
            OP_S2, OP_S3, OP_S6, OP_S12, OP_T2, OP_SW: w_op_sat = w_mul_sat;
            OP_PE:                                  w_op_sat = w_so_div[64];
            OP_PV, OP_PES, OP_PVS:                  w_op_sat = w_mul_sat | w_so_mul[64];
            OP_ACC:                                 w_op_sat = w_add_e[64] | w_add_v[64];
            default:                                w_op_sat = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_cutoff    <= CUTOFF_RESET;
            r_cuton     <= CUTON_RESET;
            r_box_x     <= 32'd0;
            r_box_y     <= 32'd0;
            r_box_z     <= 32'd0;
            r_scale     <= '0;
            r_elec      <= 64'd0;
            r_vdw       <= 64'd0;
            r_satf      <= 1'b0;
            r_coinf     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SWITCH_MODE: r_mode   <= i_cfg_data[0];
                    CFG_CUTOFF:      r_cutoff <= i_cfg_data[31:0];
                    CFG_CUTON:       r_cuton  <= i_cfg_data[31:0];
                    CFG_BOX_X:       r_box_x  <= i_cfg_data[31:0];
                    CFG_BOX_Y:       r_box_y  <= i_cfg_data[31:0];
                    CFG_BOX_Z:       r_box_z  <= i_cfg_data[31:0];
                    CFG_ELEC_SCALE:  r_scale  <= i_cfg_data;
                    default:         r_mode   <= r_mode;
                endcase
            end
            if (i_cmd.save && i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.save) begin
                case (i_cmd.op)
                    OP_ACC: begin
                        r_elec <= w_add_e[63:0];
                        r_vdw  <= w_add_v[63:0];
                    end
                    OP_FLAGS: begin
                        r_satf  <= r_satf | r_isat;
                        r_coinf <= r_coinf | (r_r2 == 64'd0);
                    end
                    OP_EMIT: begin
                        r_elec  <= 64'd0;
                        r_vdw   <= 64'd0;
                        r_satf  <= 1'b0;
                        r_coinf <= 1'b0;
                    end
                    default: r_coinf <= r_coinf;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.save) begin
            if (i_cmd.op != OP_LOAD) begin
                r_isat <= r_isat | w_op_sat;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_in   <= i_in_data;
                    r_r2   <= 64'd0;
                    r_isat <= 1'b0;
                end
                OP_DIFF: r_d      <= w_diff;
                OP_FIX:  r_d      <= w_m;
                OP_SQ:   r_r2     <= w_r2_sum[64] ? '1 : w_r2_sum[63:0];
                OP_CUT:  r_ctoff2 <= w_mul_res;
                OP_CTN:  r_cton2  <= w_mul_res;
                OP_SQRT: r_r      <= w_root;
                OP_QM:   r_qmag   <= w_mul_res;
                OP_PE:   r_pe     <= w_so_div[63:0];
                OP_S:    r_s      <= w_div_quo;
                OP_S2:   r_s2     <= w_mul_res;
                OP_S3:   r_s3     <= w_mul_res;
                OP_S6:   r_s6     <= w_mul_res;
                OP_S12:  r_s12    <= w_mul_res;
                OP_EP:   r_eprod  <= w_mul_res;
                OP_PV:   r_pv     <= w_so_mul[63:0];
                OP_T:    r_t      <= {32'b0, w_div_quo[31:0]};
                OP_T2:   r_t2     <= w_mul_res;
                OP_SW:   r_sw     <= w_mul_res;
                OP_PES:  r_pe     <= w_so_mul[63:0];
                OP_PVS:  r_pv     <= w_so_mul[63:0];
                OP_TE: begin
                    r_te   <= w_so_mul[63:0];
                    r_fsat <= w_mul_sat | w_so_mul[64];
                end
                OP_EMIT: begin
                    r_out.total_elec    <= r_te;
                    r_out.total_vdw     <= w_tv_ok ? {r_vdw[61:0], 2'b0}
                                                   : (r_vdw[63] ? S64_MIN : S64_MAX);
                    r_out.saturated     <= r_satf | r_fsat | ~w_tv_ok;
                    r_out.zero_distance <= r_coinf;
                end
                default: r_r <= r_r;
            endcase
        end
    end

    assign o_stat.done      = w_mul_done | w_div_done | w_sqrt_done;
    assign o_stat.box_zero  = (w_box == 32'd0);
    assign o_stat.r2_zero   = (r_r2 == 64'd0);
    assign o_stat.beyond    = r_mode && (r_r2 > r_ctoff2);
    assign o_stat.in_switch = r_mode && (r_r2 > r_cton2);
    assign o_stat.last      = r_in.last_pair;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== design/pair_coulomb_lj_energy_accumulator.sv =====
`default_nettype none
// Port group   Direction  Handshake                 Word
// input        in         i_in_valid / o_in_ready   i_in_data  (one atom pair)
// output       out        o_out_valid / i_out_ready o_out_data (totals after last pair)
// config       in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One pair at a time. A pair at zero distance or beyond the cutoff skips the energy
// terms; each wrapped axis adds a modulo reduction, a pair inside the switching band
// adds the switch terms and the last pair adds the scaling and emit steps. The shared
// radix-2 divider (64 steps for the Coulomb and sigma quotients, 33 per wrapped axis,
// 32 for the switch fraction), the 32-step square root and the four-product multiplier
// do this arithmetic. Reset is synchronous and needs no clearing pass. A waiting result
// holds its register while the next pair is taken; only the final emit step stalls on it.
module pair_coulomb_lj_energy_accumulator
    import pclj_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_word              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_word                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    pclj_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    pclj_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
`default_nettype wire
